// ----- hdl/rlp_pkg.sv -----
`default_nettype none
package rlp_pkg;
  localparam int unsigned CountWidth = 16;
  localparam int unsigned NumSensors = 6;
  localparam int unsigned NormWidth = 10;
  localparam int unsigned PosWidth = 13;
  localparam int unsigned NormScale = 1000;
  // dividend: scaled numerator, up to 1000*15*1000 = 1.5e7 < 2^24; 1000*65535 < 2^26
  localparam int unsigned DivWidth = 26;
  localparam logic [1:0] ReqMeasure = 2'd0;
  localparam logic [1:0] ReqCalStart = 2'd1;
  localparam logic [1:0] ReqCalMore = 2'd2;
  localparam int unsigned SelWidth = 3;
endpackage
`default_nettype wire

// ----- hdl/rlp_div.sv -----
`default_nettype none
module rlp_div (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire logic start_i,
  input  wire logic [rlp_pkg::DivWidth-1:0] num_i,
  input  wire logic [rlp_pkg::DivWidth-1:0] den_i,
  output logic done_o,
  output logic [rlp_pkg::DivWidth-1:0] quo_o
);
  import rlp_pkg::*;

  localparam int unsigned CntW = $clog2(DivWidth + 1);

  logic [DivWidth-1:0] rem_q, rem_d, quo_q, quo_d, den_q, den_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic busy_q, busy_d, done_q, done_d;
  logic [DivWidth:0] trial;
  logic [DivWidth:0] shifted;

  always_comb begin
    rem_d = rem_q;
    quo_d = quo_q;
    den_d = den_q;
    cnt_d = cnt_q;
    busy_d = busy_q;
    done_d = 1'b0;
    shifted = {rem_q, quo_q[DivWidth-1]};
    trial = shifted - {1'b0, den_q};
    if (start_i) begin
      rem_d = '0;
      quo_d = num_i;
      den_d = den_i;
      cnt_d = CntW'(DivWidth);
      busy_d = 1'b1;
    end else if (busy_q) begin
      // one quotient bit per cycle
      if (!trial[DivWidth]) begin
        rem_d = trial[DivWidth-1:0];
        quo_d = {quo_q[DivWidth-2:0], 1'b1};
      end else begin
        rem_d = shifted[DivWidth-1:0];
        quo_d = {quo_q[DivWidth-2:0], 1'b0};
      end
      cnt_d = cnt_q - 1'b1;
      if (cnt_q == CntW'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    quo_q <= quo_d;
    den_q <= den_d;
  end

  assign done_o = done_q;
  assign quo_o = quo_q;
endmodule
`default_nettype wire

// ----- hdl/reflectance_line_position.sv -----
// Reflectance line position: six discharge counts in, six normalized
// readings and a weighted line position out, one result beat per input beat.
// Input channel: in_valid_i / in_stall_o with req_type_i and count_*_i.
// Output channel: out_valid_o / out_stall_i with position_o, no_signal_o and
// norm_*_o, held in an output register until taken.
// Calibration beats (start or extend the min/max window) skip the divider.
// Measure beats run up to seven divisions through one shared bit-serial
// restoring divider, one quotient bit per cycle over 26 bits; sensors with
// a zero span skip their division, and a zero sum skips the position one.
// One beat is processed at a time; the next is accepted once the result
// register is free or being taken.
// Reset clears the window to all zero and empties the result register.
// While the receiver stalls, the result holds and no new beat is taken
// after the current one completes.
`default_nettype none
module reflectance_line_position (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire logic in_valid_i,
  output logic in_stall_o,
  input  wire logic [1:0] req_type_i,
  input  wire logic [15:0] count_0_i,
  input  wire logic [15:0] count_1_i,
  input  wire logic [15:0] count_2_i,
  input  wire logic [15:0] count_3_i,
  input  wire logic [15:0] count_4_i,
  input  wire logic [15:0] count_5_i,
  output logic out_valid_o,
  input  wire logic out_stall_i,
  output logic [12:0] position_o,
  output logic no_signal_o,
  output logic [9:0] norm_0_o,
  output logic [9:0] norm_1_o,
  output logic [9:0] norm_2_o,
  output logic [9:0] norm_3_o,
  output logic [9:0] norm_4_o,
  output logic [9:0] norm_5_o
);
  import rlp_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE, S_CLAMP, S_START, S_WAIT, S_POS, S_PWAIT, S_OUT
  } state_e;

  state_e state_q;
  logic [CountWidth-1:0] min_q [NumSensors];
  logic [CountWidth-1:0] max_q [NumSensors];
  logic [CountWidth-1:0] cnt_q [NumSensors];
  logic [NormWidth-1:0] norm_q [NumSensors];
  logic [SelWidth-1:0] sel_q;
  logic [DivWidth-1:0] wsum_q, nsum_q;
  logic [PosWidth-1:0] pos_q;
  logic nosig_q, out_valid_q, zero_q;

  logic [CountWidth-1:0] cin [NumSensors];
  assign cin[0] = count_0_i[CountWidth-1:0];
  assign cin[1] = count_1_i[CountWidth-1:0];
  assign cin[2] = count_2_i[CountWidth-1:0];
  assign cin[3] = count_3_i[CountWidth-1:0];
  assign cin[4] = count_4_i[CountWidth-1:0];
  assign cin[5] = count_5_i[CountWidth-1:0];

  logic out_free, in_acc;
  assign out_free = !out_valid_q || !out_stall_i;
  // the result register doubles as working storage: hold input until it drains
  assign in_stall_o = !((state_q == S_IDLE) && out_free);
  assign in_acc = in_valid_i && (state_q == S_IDLE) && out_free;

  // divider operands: selected sensor or the position quotient
  logic div_start, div_done;
  logic [DivWidth-1:0] div_num, div_den, div_quo;
  logic [CountWidth-1:0] smin, smax, scnt;
  assign smin = min_q[sel_q];
  assign smax = max_q[sel_q];
  assign scnt = cnt_q[sel_q];

  always_comb begin
    div_start = 1'b0;
    div_num = DivWidth'(scnt - smin) * DivWidth'(NormScale);
    div_den = DivWidth'(smax - smin);
    if (state_q == S_START && smax > smin) div_start = 1'b1;
    if (state_q == S_POS) begin
      div_start = !zero_q;
      div_num = wsum_q * DivWidth'(NormScale);
      div_den = nsum_q;
    end
  end

  rlp_div u_div (
    .clk_i(clk_i), .rst_ni(rst_ni), .start_i(div_start),
    .num_i(div_num), .den_i(div_den), .done_o(div_done), .quo_o(div_quo)
  );

  logic [NormWidth-1:0] nval;
  assign nval = (smax > smin) ? div_quo[NormWidth-1:0] : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      out_valid_q <= 1'b0;
      sel_q <= '0;
      zero_q <= 1'b0;
      wsum_q <= '0;
      nsum_q <= '0;
      pos_q <= '0;
      nosig_q <= 1'b0;
      for (int i = 0; i < NumSensors; i++) begin
        min_q[i] <= '0;
        max_q[i] <= '0;
        cnt_q[i] <= '0;
        norm_q[i] <= '0;
      end
    end else begin
      if (out_valid_q && !out_stall_i && state_q != S_OUT) out_valid_q <= 1'b0;
      case (state_q)
        S_IDLE: begin
          if (in_acc) begin
            sel_q <= '0;
            wsum_q <= '0;
            nsum_q <= '0;
            for (int i = 0; i < NumSensors; i++) begin
              cnt_q[i] <= cin[i];
              norm_q[i] <= '0;
            end
            pos_q <= '0;
            nosig_q <= 1'b0;
            if (req_type_i == ReqMeasure) begin
              state_q <= S_CLAMP;
            end else begin
              for (int i = 0; i < NumSensors; i++) begin
                if (req_type_i == ReqCalStart) begin
                  min_q[i] <= cin[i];
                  max_q[i] <= cin[i];
                end else if (cin[i] < min_q[i]) begin
                  min_q[i] <= cin[i];
                end else if (cin[i] >= max_q[i]) begin
                  max_q[i] <= cin[i];
                end
              end
              state_q <= S_OUT;
            end
          end
        end
        S_CLAMP: begin
          for (int i = 0; i < NumSensors; i++) begin
            if (cnt_q[i] < min_q[i]) begin
              cnt_q[i] <= (min_q[i] + 1'b1 > max_q[i]) ? max_q[i] - 1'b1 : min_q[i] + 1'b1;
            end else if (cnt_q[i] > max_q[i]) begin
              cnt_q[i] <= max_q[i] - 1'b1;
            end
          end
          state_q <= S_START;
        end
        S_START: begin
          if (smax > smin) begin
            state_q <= S_WAIT;
          end else if (sel_q == SelWidth'(NumSensors - 1)) begin
            // zero span: norm stays 0, advance
            zero_q <= (nsum_q == '0);
            state_q <= S_POS;
          end else begin
            sel_q <= sel_q + 1'b1;
          end
        end
        S_WAIT: begin
          if (div_done) begin
            norm_q[sel_q] <= nval;
            nsum_q <= nsum_q + DivWidth'(nval);
            wsum_q <= wsum_q + DivWidth'(nval) * DivWidth'(sel_q);
            if (sel_q == SelWidth'(NumSensors - 1)) begin
              zero_q <= (nsum_q + DivWidth'(nval) == '0);
              state_q <= S_POS;
            end else begin
              sel_q <= sel_q + 1'b1;
              state_q <= S_START;
            end
          end
        end
        S_POS: begin
          if (zero_q) begin
            nosig_q <= 1'b1;
            state_q <= S_OUT;
          end else begin
            state_q <= S_PWAIT;
          end
        end
        S_PWAIT: begin
          if (div_done) begin
            pos_q <= div_quo[PosWidth-1:0];
            state_q <= S_OUT;
          end
        end
        S_OUT: begin
          if (out_free) begin
            out_valid_q <= 1'b1;
            state_q <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  assign out_valid_o = out_valid_q;
  assign position_o = pos_q;
  assign no_signal_o = nosig_q;
  assign norm_0_o = norm_q[0];
  assign norm_1_o = norm_q[1];
  assign norm_2_o = norm_q[2];
  assign norm_3_o = norm_q[3];
  assign norm_4_o = norm_q[4];
  assign norm_5_o = norm_q[5];
endmodule
`default_nettype wire

// ----- tb/sv/tb_reflectance_line_position.sv -----
`timescale 1ns / 100ps
`default_nettype none
module tb_reflectance_line_position;
  import rlp_pkg::*;

  typedef struct packed {
    logic [1:0]  req;
    logic [15:0] cnt0, cnt1, cnt2, cnt3, cnt4, cnt5;
  } reading_t;

  typedef struct packed {
    logic [12:0] pos;
    logic        nosig;
    logic [9:0]  n0, n1, n2, n3, n4, n5;
  } line_fix_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic in_valid_i = 1'b0;
  logic out_stall_i = 1'b0;
  logic [1:0] req_type_i = ReqMeasure;
  logic [15:0] count_0_i = '0, count_1_i = '0, count_2_i = '0;
  logic [15:0] count_3_i = '0, count_4_i = '0, count_5_i = '0;
  logic in_stall_o, out_valid_o, no_signal_o;
  logic [12:0] position_o;
  logic [9:0] norm_0_o, norm_1_o, norm_2_o, norm_3_o, norm_4_o, norm_5_o;

  reflectance_line_position i_dut (.*);

  always #6 clk_i = ~clk_i;

  reading_t  pending_readings[$];
  line_fix_t expected_fixes[$];
  logic [15:0] win_min[NumSensors];
  logic [15:0] win_max[NumSensors];
  int errors = 0;
  int n_sent = 0, n_got = 0, n_meas = 0, n_nosig = 0;
  int hold_off = 0;       // receiver hold-off in cycles
  bit pause_drain = 0;    // sender waits until all results came
  bit stim_done = 0;

  function automatic logic [9:0] norm_one(logic [15:0] c, logic [15:0] lo, logic [15:0] hi);
    int unsigned v;
    if (hi <= lo) return '0;
    v = c;
    if (v < lo) v = lo + 1;
    if (v > hi) v = hi - 1;
    return 10'((NormScale * (v - lo)) / (hi - lo));
  endfunction

  function automatic line_fix_t locate_line(reading_t r);
    line_fix_t f;
    logic [15:0] c[NumSensors];
    logic [9:0] n[NumSensors];
    int unsigned wsum, nsum;
    c = '{r.cnt0, r.cnt1, r.cnt2, r.cnt3, r.cnt4, r.cnt5};
    f = '0;
    wsum = 0;
    nsum = 0;
    if (r.req == ReqCalStart) begin
      for (int i = 0; i < NumSensors; i++) begin
        win_min[i] = c[i];
        win_max[i] = c[i];
      end
    end else if (r.req != ReqMeasure) begin
      for (int i = 0; i < NumSensors; i++) begin
        if (c[i] < win_min[i]) win_min[i] = c[i];
        else if (c[i] >= win_max[i]) win_max[i] = c[i];
      end
    end else begin
      for (int i = 0; i < NumSensors; i++) begin
        n[i] = norm_one(c[i], win_min[i], win_max[i]);
        wsum += i * n[i];
        nsum += n[i];
      end
      {f.n0, f.n1, f.n2, f.n3, f.n4, f.n5} = {n[0], n[1], n[2], n[3], n[4], n[5]};
      if (nsum == 0) f.nosig = 1'b1;
      else f.pos = 13'((NormScale * wsum) / nsum);
    end
    return f;
  endfunction

  task automatic report_mismatch(string what, int got, int exp_v);
    $display("mismatch %s: got %0d expected %0d (result %0d)", what, got, exp_v, n_got);
    errors++;
  endtask

  function automatic int gap_len();
    if ($urandom_range(0, 2) == 0) return 0;
    if ($urandom_range(0, 19) == 0) return $urandom_range(20, 300);
    return $urandom_range(1, 4);
  endfunction

  function automatic logic [15:0] rcount();
    case ($urandom_range(0, 5))
      0: return 16'h0000;
      1: return 16'hffff;
      default: return 16'($urandom);
    endcase
  endfunction

  task automatic add_reading(logic [1:0] q, logic [15:0] a, b, c, d, e, g);
    reading_t r;
    r = '{q, a, b, c, d, e, g};
    pending_readings.push_back(r);
  endtask

  // stall seen at the last rising edge, so the driver knows if its beat went in
  logic in_stall_o_q = 1'b1;

  // driver: present beats at the falling edge
  int tx_gap = 0;
  reading_t cur;
  always @(negedge clk_i) begin
    if (rst_ni) begin
      if (in_valid_i && !in_stall_o_q) begin
        tx_gap = gap_len();
      end
      if (!(in_valid_i && in_stall_o_q)) begin
        if (tx_gap > 0) begin
          tx_gap--;
          in_valid_i <= 1'b0;
        end else if (pending_readings.size() > 0 &&
                     !(pause_drain && expected_fixes.size() > 0)) begin
          cur = pending_readings.pop_front();
          in_valid_i <= 1'b1;
          req_type_i <= cur.req;
          {count_0_i, count_1_i, count_2_i, count_3_i, count_4_i, count_5_i} <=
            {cur.cnt0, cur.cnt1, cur.cnt2, cur.cnt3, cur.cnt4, cur.cnt5};
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  // receiver: random stalls, or a long hold-off counted down here
  always @(negedge clk_i) begin
    if (rst_ni) begin
      if (hold_off > 0) begin
        hold_off--;
        out_stall_i <= 1'b1;
      end else begin
        out_stall_i <= ($urandom_range(0, 3) == 0) ? 1'b1 : 1'b0;
      end
    end
  end

  always @(posedge clk_i) begin
    in_stall_o_q <= in_stall_o;
    if (rst_ni && in_valid_i && !in_stall_o) begin
      expected_fixes.push_back(locate_line({req_type_i, count_0_i, count_1_i, count_2_i,
                                            count_3_i, count_4_i, count_5_i}));
      n_sent++;
    end
  end

  // monitor
  line_fix_t want;
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (expected_fixes.size() == 0) begin
        report_mismatch("unexpected beat", 1, 0);
      end else begin
        want = expected_fixes.pop_front();
        if (position_o !== want.pos) report_mismatch("position", position_o, want.pos);
        if (no_signal_o !== want.nosig) report_mismatch("no_signal", no_signal_o, want.nosig);
        if (norm_0_o !== want.n0) report_mismatch("norm_0", norm_0_o, want.n0);
        if (norm_1_o !== want.n1) report_mismatch("norm_1", norm_1_o, want.n1);
        if (norm_2_o !== want.n2) report_mismatch("norm_2", norm_2_o, want.n2);
        if (norm_3_o !== want.n3) report_mismatch("norm_3", norm_3_o, want.n3);
        if (norm_4_o !== want.n4) report_mismatch("norm_4", norm_4_o, want.n4);
        if (norm_5_o !== want.n5) report_mismatch("norm_5", norm_5_o, want.n5);
        if (want.nosig) n_nosig++;
        if (want.n0 | want.n1 | want.n2 | want.n3 | want.n4 | want.n5 | want.nosig) n_meas++;
      end
      n_got++;
    end
  end

  initial begin
    int k;
    for (int i = 0; i < NumSensors; i++) begin
      win_min[i] = '0;
      win_max[i] = '0;
    end
    // directed: measure and extend from the reset window, wide window, clamps
    add_reading(ReqMeasure, 16'd5, 16'd0, 16'hffff, 16'd1, 16'd2, 16'd3);
    add_reading(ReqCalMore, 16'd7, 16'd0, 16'hffff, 16'd100, 16'd0, 16'd9);
    add_reading(ReqMeasure, 16'd3, 16'd0, 16'd500, 16'd200, 16'd0, 16'd9);
    add_reading(ReqCalStart, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0);
    add_reading(ReqCalMore, 16'hffff, 16'hffff, 16'hffff, 16'hffff, 16'hffff, 16'hffff);
    add_reading(ReqMeasure, 16'd0, 16'hffff, 16'd32768, 16'd1, 16'd65534, 16'd12345);
    add_reading(ReqMeasure, 16'hffff, 16'hffff, 16'hffff, 16'hffff, 16'hffff, 16'hffff);
    add_reading(ReqMeasure, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0);
    add_reading(ReqCalStart, 16'd100, 16'd100, 16'd100, 16'd100, 16'd100, 16'd100);
    add_reading(ReqMeasure, 16'd100, 16'd0, 16'd200, 16'd100, 16'd50, 16'd150);
    add_reading(2'd3, 16'd50, 16'd200, 16'd100, 16'd150, 16'd99, 16'd101);
    add_reading(ReqMeasure, 16'd40, 16'd300, 16'd100, 16'd120, 16'd99, 16'd101);
    add_reading(ReqMeasure, 16'd75, 16'd150, 16'd100, 16'd140, 16'd99, 16'd100);
    add_reading(ReqCalMore, 16'd60, 16'd90, 16'd100, 16'd140, 16'd120, 16'd100);
    add_reading(ReqMeasure, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 16'hffff);
    add_reading(ReqMeasure, 16'd60, 16'd200, 16'd100, 16'd150, 16'd99, 16'd101);
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    // random: mostly groups of a start, a few extends and several measures
    k = 0;
    while (k < 850) begin
      if ($urandom_range(0, 9) == 0) begin
        add_reading(2'($urandom), rcount(), rcount(), rcount(), rcount(), rcount(), rcount());
        k++;
      end else begin
        add_reading(ReqCalStart, rcount(), rcount(), rcount(), rcount(), rcount(), rcount());
        repeat ($urandom_range(1, 4)) begin
          add_reading($urandom_range(0, 1) ? ReqCalMore : 2'd3, rcount(), rcount(), rcount(),
                      rcount(), rcount(), rcount());
          k++;
        end
        repeat ($urandom_range(2, 6)) begin
          add_reading(ReqMeasure, rcount(), rcount(), rcount(), rcount(), rcount(), rcount());
          k++;
        end
        k++;
      end
      if (k > 300 && k < 320) begin
        // long receiver hold-off while sender keeps offering
        wait (pending_readings.size() < 5);
        hold_off = 3000;
        wait (hold_off == 0);
        pause_drain = 1;
        wait (expected_fixes.size() == 0);
        pause_drain = 0;
        k = 320;
      end
    end
    wait (pending_readings.size() == 0 && !(in_valid_i));
    wait (expected_fixes.size() == 0);
    repeat (300) @(posedge clk_i);
    $display("sent %0d beats, received %0d, %0d measures (%0d with no signal)",
             n_sent, n_got, n_meas, n_nosig);
    if (errors == 0 && expected_fixes.size() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

  initial begin
    #(12 * 2000000);
    $display("timeout, %0d results outstanding", expected_fixes.size());
    $display("[FAIL] regression broken");
    $finish;
  end
endmodule
`default_nettype wire
